// ----- design/fcca_pkg.sv -----
// Package with the shared types and codes of the cluster chain allocator.
package fcca_pkg;

   localparam logic [10:0] END_MARK = 11'h7FF;

   typedef enum logic [1:0] {
      REQ_ALLOCATE = 2'd0,
      REQ_FREE     = 2'd1,
      REQ_FOLLOW   = 2'd2,
      REQ_QUERY    = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_NOSPACE  = 3'd2,
      ST_RANGE    = 3'd3,
      ST_FREELINK = 3'd4,
      ST_END      = 3'd5
   } status_code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [10:0] cluster;
      logic [10:0] cluster_count;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] result_cluster;
      logic        contiguous;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RUN_RD,
      S_RUN_CHK,
      S_CNT_RD,
      S_CNT_CHK,
      S_RUN_WR,
      S_CHN_RD,
      S_CHN_CHK,
      S_WALK_RD,
      S_WALK_CHK,
      S_DONE
   } state_type;

   // Memory access request from the sequencer to the link table.
   typedef struct packed {
      logic        wr_en;
      logic [14:0] wr_addr;
      logic [10:0] wr_data;
      logic [14:0] rd_addr;
   } mem_req_type;

endpackage

// ----- design/fcca_link_ram.sv -----
// Link table memory with one write port and one registered read port.
module fcca_link_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW = 10
) (
   input  logic                 clock,
   input  fcca_pkg::mem_req_type mem_req,
   output logic [10:0]          rd_data
);
   import fcca_pkg::*;

   logic [10:0] mem [DEPTH];

   // Write and registered read; a read of the entry written in the same cycle sees the old value.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      rd_data <= mem[mem_req.rd_addr[AW-1:0]];
   end

endmodule

// ----- design/fat_cluster_chain_allocator.sv -----
// Top level of the cluster chain allocator: request sequencer around the link table.
//
// Usage: one request item enters on req_ (valid/stall) and gives exactly one result
// item on rsp_. Requests are served one at a time; req_stall is high while an item
// is in work or its result has not been taken.
// Work per request, from the item taken to the result offered (the link table's read
// port is registered, so each entry examined takes a read state and a check state):
//   bad requests and zero counts go straight to the result; follow reads one entry;
//   free reads and clears each chain entry in turn;
//   query reads each entry checked in turn;
//   allocate scans the table for a free run; when no run fits, or the count exceeds
//   the table, it counts the free entries and, if enough are free, chains them.
//   A run found is written one entry per cycle.
// After the result is taken the block goes idle and then takes the next item.
// Reset: a clearing pass writes every entry, one per cycle; entries 0 and 1 get the end
// mark. No item is accepted during the pass.
// When the receiver stalls, the result holds on rsp_ and no new item is accepted.
module fat_cluster_chain_allocator #(
   parameter int unsigned TABLE_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fcca_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fcca_pkg::rsp_item_type rsp_data
);
   import fcca_pkg::*;

   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [15:0] NENT = 16'(TABLE_ENTRIES);

   state_type    state_ff, state_in;
   req_item_type req_ff, req_in;
   rsp_item_type rsp_ff, rsp_in;
   logic [15:0]  idx_ff, idx_in;     // scan or walk position
   logic [15:0]  start_ff, start_in; // run start
   logic [15:0]  run_ff, run_in;     // run length or free count
   logic [15:0]  prev_ff, prev_in;
   logic         found_ff, found_in;
   mem_req_type  mreq;
   logic [10:0]  rd_data;

   fcca_link_ram #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_ram (
      .clock   (clock),
      .mem_req (mreq),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      start_ff <= start_in;
      run_ff   <= run_in;
      prev_ff  <= prev_in;
      found_ff <= found_in;
   end

   logic [15:0] cnt16, clu16, stop16, last16;
   assign cnt16  = {5'd0, req_ff.cluster_count};
   assign clu16  = {5'd0, req_ff.cluster};
   assign stop16 = clu16 + cnt16;
   assign last16 = start_ff + cnt16 - 16'd1;

   // Sequencer: next state, memory access and result.
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      run_in   = run_ff;
      prev_in  = prev_ff;
      found_in = found_ff;
      mreq     = '0;
      mreq.rd_addr = idx_ff[14:0];
      unique case (state_ff)
         S_CLEAR: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = idx_ff[14:0];
            mreq.wr_data = (idx_ff < 16'd2) ? END_MARK : 11'd0;
            idx_in = idx_ff + 16'd1;
            if (idx_ff == NENT - 16'd1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               idx_in = {5'd0, req_data.cluster};
               run_in = '0;
               found_in = 1'b0;
               unique case (req_data.req_type)
                  REQ_ALLOCATE: begin
                     idx_in = '0;
                     if (req_data.cluster_count == 11'd0) begin
                        rsp_in.status = ST_ZERO;
                        state_in = S_DONE;
                     end else if ({5'd0, req_data.cluster_count} <= NENT) begin
                        state_in = S_RUN_RD;
                     end else begin
                        state_in = S_CNT_RD;
                     end
                  end
                  REQ_FREE, REQ_FOLLOW: begin
                     if ({5'd0, req_data.cluster} >= NENT) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_WALK_RD;
                     end
                  end
                  default: begin
                     if ({5'd0, req_data.cluster} >= NENT) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_DONE;
                     end else if (req_data.cluster_count == 11'd0) begin
                        rsp_in.status = ST_ZERO;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_WALK_RD;
                     end
                  end
               endcase
            end
         end
         S_RUN_RD: state_in = S_RUN_CHK;
         S_RUN_CHK: begin
            if (rd_data == 11'd0) begin
               if (run_ff == 16'd0) start_in = idx_ff;
               run_in = run_ff + 16'd1;
               if (run_ff + 16'd1 == cnt16) begin
                  if (run_ff == 16'd0) start_in = idx_ff;
                  idx_in = (run_ff == 16'd0) ? idx_ff : start_ff;
                  state_in = S_RUN_WR;
               end
            end else begin
               run_in = '0;
            end
            if (state_in != S_RUN_WR) begin
               if (idx_ff == NENT - 16'd1) begin
                  idx_in = '0;
                  run_in = '0;
                  state_in = S_CNT_RD;
               end else begin
                  idx_in = idx_ff + 16'd1;
                  state_in = S_RUN_RD;
               end
            end
         end
         S_RUN_WR: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = idx_ff[14:0];
            mreq.wr_data = (idx_ff == last16) ? END_MARK : 11'(idx_ff + 16'd1);
            idx_in = idx_ff + 16'd1;
            if (idx_ff == last16) begin
               // A chained allocation already holds its first cluster.
               if (!found_ff) rsp_in.result_cluster = 11'(start_ff);
               state_in = S_DONE;
            end
         end
         S_CNT_RD: state_in = S_CNT_CHK;
         S_CNT_CHK: begin
            if (rd_data == 11'd0) run_in = run_ff + 16'd1;
            if (idx_ff == NENT - 16'd1) begin
               idx_in = '0;
               if (((rd_data == 11'd0) ? run_ff + 16'd1 : run_ff) < cnt16) begin
                  rsp_in.status = ST_NOSPACE;
                  state_in = S_DONE;
               end else begin
                  run_in = cnt16;
                  state_in = S_CHN_RD;
               end
            end else begin
               idx_in = idx_ff + 16'd1;
               state_in = S_CNT_RD;
            end
         end
         S_CHN_RD: state_in = S_CHN_CHK;
         S_CHN_CHK: begin
            idx_in = idx_ff + 16'd1;
            state_in = S_CHN_RD;
            if (rd_data == 11'd0) begin
               if (!found_ff) begin
                  found_in = 1'b1;
                  rsp_in.result_cluster = 11'(idx_ff);
               end else begin
                  mreq.wr_en   = 1'b1;
                  mreq.wr_addr = prev_ff[14:0];
                  mreq.wr_data = 11'(idx_ff);
               end
               prev_in = idx_ff;
               run_in = run_ff - 16'd1;
               if (run_ff == 16'd1) state_in = S_RUN_WR;
               if (run_ff == 16'd1) begin
                  start_in = idx_ff;
                  idx_in   = idx_ff;
                  // Reuse the run writer for the single end mark.
                  req_in.cluster_count = 11'd1;
                  found_in = 1'b1;
                  rsp_in.result_cluster = found_ff ? rsp_ff.result_cluster : 11'(idx_ff);
               end
            end
         end
         S_WALK_RD: state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            state_in = S_DONE;
            unique case (req_ff.req_type)
               REQ_FREE: begin
                  if (rd_data == 11'd0) begin
                     rsp_in.status = ST_FREELINK;
                  end else begin
                     mreq.wr_en   = 1'b1;
                     mreq.wr_addr = idx_ff[14:0];
                     mreq.wr_data = 11'd0;
                     if (rd_data == END_MARK) begin
                        rsp_in.status = ST_OK;
                     end else if ({5'd0, rd_data} >= NENT) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        idx_in = {5'd0, rd_data};
                        state_in = S_WALK_RD;
                     end
                  end
               end
               REQ_FOLLOW: begin
                  rsp_in.result_cluster = rd_data;
                  if (rd_data == END_MARK)             rsp_in.status = ST_END;
                  else if (rd_data == 11'd0)            rsp_in.status = ST_FREELINK;
                  else if ({5'd0, rd_data} >= NENT)     rsp_in.status = ST_RANGE;
                  else                                  rsp_in.status = ST_OK;
               end
               default: begin
                  if (rd_data == END_MARK) begin
                     rsp_in.contiguous = (idx_ff + 16'd1 == stop16);
                  end else if ({5'd0, rd_data} != idx_ff + 16'd1) begin
                     rsp_in.contiguous = 1'b0;
                  end else if ((idx_ff + 16'd1 >= stop16) ||
                               (idx_ff + 16'd1 >= NENT)) begin
                     rsp_in.contiguous = 1'b0;
                  end else begin
                     idx_in = idx_ff + 16'd1;
                     state_in = S_WALK_RD;
                  end
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
